// File: rtl/core/usbcr_pkg.sv
// ============================================================================
// USB control responder package
// Shared types, codes, descriptor table and lookup functions for the
// endpoint-0 control request responder.
// ============================================================================
package usbcr_pkg;

    // Default largest packet on endpoint 0, in bytes.
    localparam int MAX_PACKET_DEF = 64;
    // Bytes held in the descriptor table; higher indexes read as zero.
    localparam int ROM_BYTES = 144;
    // Width of a run count; it holds the largest packet size that is allowed.
    localparam int CNT_W = 7;

    // Item actions.
    localparam logic [1:0] ACT_SETUP = 2'd0;
    localparam logic [1:0] ACT_IN    = 2'd1;
    localparam logic [1:0] ACT_RESET = 2'd2;

    // Request codes.
    localparam logic [7:0] REQ_GET_STATUS     = 8'h00;
    localparam logic [7:0] REQ_SET_ADDRESS    = 8'h05;
    localparam logic [7:0] REQ_GET_DESCRIPTOR = 8'h06;
    localparam logic [7:0] REQ_GET_CONFIG     = 8'h08;
    localparam logic [7:0] REQ_SET_CONFIG     = 8'h09;
    localparam logic [7:0] REQ_SET_LINE_CODING = 8'h20;
    localparam logic [7:0] REQ_GET_LINE_CODING = 8'h21;
    localparam logic [7:0] REQ_SET_LINE_STATE  = 8'h22;

    // Descriptor types.
    localparam logic [7:0] DESC_DEVICE = 8'd1;
    localparam logic [7:0] DESC_CONFIG = 8'd2;
    localparam logic [7:0] DESC_STRING = 8'd3;
    localparam logic [7:0] STRING_LAST = 8'd2;

    // Fixed places of the descriptors in the table.
    localparam logic [7:0] CFG_OFFSET = 8'd18;
    localparam logic [7:0] CFG_LENGTH = 8'd98;

    // Reply kinds.
    localparam logic [2:0] KIND_DATA  = 3'd0;
    localparam logic [2:0] KIND_EMPTY = 3'd1;
    localparam logic [2:0] KIND_NONE  = 3'd2;
    localparam logic [2:0] KIND_STALL = 3'd3;
    localparam logic [2:0] KIND_RESET = 3'd4;

    // Byte sources of a run.
    localparam logic [1:0] SRC_NONE = 2'd0;
    localparam logic [1:0] SRC_ROM  = 2'd1;
    localparam logic [1:0] SRC_FIX  = 2'd2;

    // Fixed reply patterns.
    localparam logic [1:0] FIX_ZERO   = 2'd0;
    localparam logic [1:0] FIX_CONFIG = 2'd1;
    localparam logic [1:0] FIX_LINE   = 2'd2;

    // Line reset value of the reported baud rate.
    localparam logic [31:0] LINE_RATE_RESET = 32'd115200;

    // One run of results handed from the sequencer to the byte unit.
    typedef struct packed {
        logic [1:0]       src;
        logic [2:0]       kind;
        logic [1:0]       fix;
        logic [CNT_W-1:0] cnt;
        logic [7:0]       ptr;
        logic             more;
    } t_run;

    // Device state that every result carries or that fixed replies read.
    typedef struct packed {
        logic        addr_load;
        logic [6:0]  dev_addr;
        logic [7:0]  config_value;
        logic [7:0]  line_state;
        logic [31:0] line_rate;
    } t_ctx;

    localparam logic [7:0] DESC_ROM [0:ROM_BYTES-1] = '{
        // Device descriptor.
        8'd18, 8'd1, 8'h00, 8'h02, 8'd0, 8'd0, 8'd0, 8'd64, 8'ha2, 8'h15, 8'h42,
        8'h00, 8'h00, 8'h01, 8'd1, 8'd2, 8'd0, 8'd1,
        // Configuration descriptor.
        8'd9, 8'd2, 8'd98, 8'd0, 8'd3, 8'd1, 8'd0, 8'h80, 8'd50,
        8'd9, 8'd4, 8'd0, 8'd0, 8'd2, 8'hff, 8'hff, 8'hff, 8'd0,
        8'd7, 8'd5, 8'h82, 8'd2, 8'd64, 8'd0, 8'd0,
        8'd7, 8'd5, 8'h01, 8'd2, 8'd64, 8'd0, 8'd0,
        8'd8, 8'd11, 8'd1, 8'd2, 8'd2, 8'd2, 8'd1, 8'd0,
        8'd9, 8'd4, 8'd1, 8'd0, 8'd1, 8'd2, 8'd2, 8'd0, 8'd0,
        8'd5, 8'h24, 8'd0, 8'h10, 8'h01,
        8'd5, 8'h24, 8'd1, 8'd1, 8'd1,
        8'd4, 8'h24, 8'd2, 8'd6,
        8'd5, 8'h24, 8'd6, 8'd1, 8'd2,
        8'd7, 8'd5, 8'h84, 8'd3, 8'd64, 8'd0, 8'd100,
        8'd9, 8'd4, 8'd2, 8'd0, 8'd2, 8'h0a, 8'd0, 8'd0, 8'd0,
        8'd7, 8'd5, 8'h83, 8'd2, 8'd64, 8'd0, 8'd0,
        8'd7, 8'd5, 8'h03, 8'd2, 8'd64, 8'd0, 8'd0,
        // String descriptor 0.
        8'h04, 8'h03, 8'h09, 8'h04,
        // String descriptor 1.
        8'h0e, 8'h03, 8'h72, 8'h00, 8'h61, 8'h00, 8'h6e, 8'h00, 8'h6d, 8'h00,
        8'h61, 8'h00, 8'h40, 8'h00,
        // String descriptor 2.
        8'h0a, 8'h03, 8'h54, 8'h00, 8'h65, 8'h00, 8'h73, 8'h00, 8'h74, 8'h00
    };

    // Table read; an index past the end reads as zero.
    function automatic logic [7:0] rom_byte(input logic [7:0] idx);
        logic [7:0] b;
        b = 8'd0;
        if (32'(idx) < ROM_BYTES) begin
            b = DESC_ROM[idx];
        end
        return b;
    endfunction

    // Table offset of a string descriptor, for indexes up to STRING_LAST.
    function automatic logic [7:0] string_offset(input logic [1:0] idx);
        logic [7:0] off;
        case (idx)
            2'd0:    off = 8'd116;
            2'd1:    off = 8'd120;
            default: off = 8'd134;
        endcase
        return off;
    endfunction

    // Builds a run descriptor.
    function automatic t_run make_run(input logic [1:0] src, input logic [2:0] kind,
                                      input logic [1:0] fix, input logic [CNT_W-1:0] cnt,
                                      input logic [7:0] ptr, input logic more);
        t_run r;
        r.src  = src;
        r.kind = kind;
        r.fix  = fix;
        r.cnt  = cnt;
        r.ptr  = ptr;
        r.more = more;
        return r;
    endfunction

endpackage

// File: rtl/core/usbcr_if.sv
// ============================================================================
// USB control responder channels
// Valid/ready channels for request items and for result beats.
// ============================================================================

// Request items: one beat per setup, IN acknowledgement or bus reset.
interface usbcr_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  action;
    logic [7:0]  request_code;
    logic [15:0] request_value;
    logic [15:0] request_length;

    modport source (output valid, action, request_code, request_value, request_length,
                    input ready);
    modport sink (input valid, action, request_code, request_value, request_length,
                  output ready);
endinterface

// Result beats: one per response byte or status result.
interface usbcr_rsp_if;
    logic       valid;
    logic       ready;
    logic [2:0] reply_kind;
    logic [7:0] data_byte;
    logic       last;
    logic       more_to_come;
    logic       address_load;
    logic [6:0] device_address;
    logic [7:0] configuration;

    modport source (output valid, reply_kind, data_byte, last, more_to_come, address_load,
                    device_address, configuration, input ready);
    modport sink (input valid, reply_kind, data_byte, last, more_to_come, address_load,
                  device_address, configuration, output ready);
endinterface

// File: rtl/core/usbcr_emit.sv
// ============================================================================
// USB control responder byte unit
// Walks one run of results, one beat per cycle while o_rsp accepts them,
// reading the descriptor table or a fixed pattern, into a registered output stage.
// ============================================================================
module usbcr_emit
    import usbcr_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  t_run              i_run,
    input  t_ctx              i_ctx,
    output logic              o_busy,
    usbcr_rsp_if.source       o_rsp
);

    logic [CNT_W-1:0] r_cnt;
    logic [7:0]       r_ptr;
    logic [2:0]       r_idx;
    logic [1:0]       r_src;
    logic [1:0]       r_fix;
    logic [2:0]       r_kind;
    logic             r_more;

    logic             r_ov;
    logic [2:0]       r_out_kind;
    logic [7:0]       r_out_byte;
    logic             r_out_last;
    logic             r_out_more;
    logic             r_out_load;
    logic [6:0]       r_out_addr;
    logic [7:0]       r_out_config;

    logic             take;
    logic [7:0]       fix_byte;
    logic [7:0]       next_byte;

    // A beat is loaded whenever a run is open and the output stage frees up.
    assign take   = (r_cnt != '0) && (!r_ov || o_rsp.ready);
    assign o_busy = (r_cnt != '0);

    // Fixed reply patterns: status zeros, configuration, and line coding.
    always_comb begin
        fix_byte = 8'd0;
        case (r_fix)
            FIX_CONFIG: fix_byte = i_ctx.config_value;
            FIX_LINE: begin
                case (r_idx)
                    3'd0:    fix_byte = i_ctx.line_rate[7:0];
                    3'd1:    fix_byte = i_ctx.line_rate[15:8];
                    3'd2:    fix_byte = i_ctx.line_rate[23:16];
                    3'd3:    fix_byte = i_ctx.line_rate[31:24];
                    3'd7:    fix_byte = i_ctx.line_state;
                    default: fix_byte = 8'd0;
                endcase
            end
            default: fix_byte = 8'd0;
        endcase
    end

    // Byte source select.
    always_comb begin
        case (r_src)
            SRC_ROM: next_byte = rom_byte(r_ptr);
            SRC_FIX: next_byte = fix_byte;
            default: next_byte = 8'd0;
        endcase
    end

    // Run counter, table pointer and pattern index.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= i_run.cnt;
        end else if (take) begin
            r_cnt <= r_cnt - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_ptr  <= i_run.ptr;
            r_idx  <= 3'd0;
            r_src  <= i_run.src;
            r_fix  <= i_run.fix;
            r_kind <= i_run.kind;
            r_more <= i_run.more;
        end else if (take) begin
            r_ptr <= r_ptr + 8'd1;
            r_idx <= r_idx + 3'd1;
        end
    end

    // Output stage valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (take) begin
            r_ov <= 1'b1;
        end else if (o_rsp.ready) begin
            r_ov <= 1'b0;
        end
    end

    // Output stage payload.
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_out_kind   <= (r_src == SRC_NONE) ? r_kind : KIND_DATA;
            r_out_byte   <= next_byte;
            r_out_last   <= (r_cnt == CNT_W'(1));
            r_out_more   <= (r_src == SRC_ROM) && r_more;
            r_out_load   <= i_ctx.addr_load;
            r_out_addr   <= i_ctx.dev_addr;
            r_out_config <= i_ctx.config_value;
        end
    end

    assign o_rsp.valid          = r_ov;
    assign o_rsp.reply_kind     = r_out_kind;
    assign o_rsp.data_byte      = r_out_byte;
    assign o_rsp.last           = r_out_last;
    assign o_rsp.more_to_come   = r_out_more;
    assign o_rsp.address_load   = r_out_load;
    assign o_rsp.device_address = r_out_addr;
    assign o_rsp.configuration  = r_out_config;

endmodule

// File: rtl/core/usbcr_ctrl.sv
// ============================================================================
// USB control responder sequencer
// Decodes request items, keeps the device state and the pending transfer,
// sizes descriptor packets and starts runs on the byte unit.
// ============================================================================
module usbcr_ctrl
    import usbcr_pkg::*;
#(
    parameter int MAX_PACKET = MAX_PACKET_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [31:0]       i_cfg_wdata,
    usbcr_req_if.sink         i_req,
    input  logic              i_busy,
    output logic              o_start,
    output t_run              o_run,
    output t_ctx              o_ctx
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DESC = 2'd1;
    localparam logic [1:0] ST_SEND = 2'd2;
    localparam logic [1:0] ST_RUN  = 2'd3;

    localparam logic [7:0] MaxPkt = 8'(MAX_PACKET);

    logic [1:0]  r_state,     n_state;
    logic [7:0]  r_config,    n_config;
    logic [7:0]  r_line_st,   n_line_st;
    logic [6:0]  r_pend_addr, n_pend_addr;
    logic        r_addr_pend, n_addr_pend;
    logic [6:0]  r_cur_addr,  n_cur_addr;
    logic [7:0]  r_resp_ptr,  n_resp_ptr;
    logic [7:0]  r_resp_rem,  n_resp_rem;
    logic        r_addr_load, n_addr_load;
    logic [31:0] r_line_rate;
    logic [7:0]  r_type,      n_type;
    logic [7:0]  r_index,     n_index;
    logic [15:0] r_length,    n_length;
    logic        r_start,     n_start;
    t_run        r_run,       n_run;

    logic        d_found;
    logic [7:0]  d_off;
    logic [7:0]  d_len;
    logic [7:0]  d_clip;
    logic [7:0]  s_cnt;
    logic [7:0]  s_rem;

    assign i_req.ready = (r_state == ST_IDLE);

    // Descriptor lookup: table place, stored length, then clip to wLength.
    always_comb begin
        d_found = 1'b1;
        d_off   = 8'd0;
        d_len   = 8'd0;
        if (r_type == DESC_DEVICE) begin
            d_off = 8'd0;
            d_len = rom_byte(8'd0);
        end else if (r_type == DESC_CONFIG) begin
            d_off = CFG_OFFSET;
            d_len = CFG_LENGTH;
        end else if ((r_type == DESC_STRING) && (r_index <= STRING_LAST)) begin
            d_off = string_offset(r_index[1:0]);
            d_len = rom_byte(d_off);
        end else begin
            d_found = 1'b0;
        end
        d_clip = (r_length < {8'd0, d_len}) ? r_length[7:0] : d_len;
    end

    // Packet sizing for the pending transfer.
    always_comb begin
        s_cnt = (r_resp_rem > MaxPkt) ? MaxPkt : r_resp_rem;
        s_rem = r_resp_rem - s_cnt;
    end

    // Sequencer and device state update.
    always_comb begin
        n_state     = r_state;
        n_config    = r_config;
        n_line_st   = r_line_st;
        n_pend_addr = r_pend_addr;
        n_addr_pend = r_addr_pend;
        n_cur_addr  = r_cur_addr;
        n_resp_ptr  = r_resp_ptr;
        n_resp_rem  = r_resp_rem;
        n_addr_load = r_addr_load;
        n_type      = r_type;
        n_index     = r_index;
        n_length    = r_length;
        n_start     = 1'b0;
        n_run       = r_run;

        unique case (r_state)
            ST_IDLE: begin
                if (i_req.valid) begin
                    n_addr_load = 1'b0;
                    unique case (i_req.action)
                        ACT_SETUP: begin
                            // A new setup drops any transfer still in flight.
                            n_resp_ptr = 8'd0;
                            n_resp_rem = 8'd0;
                            n_state    = ST_RUN;
                            n_start    = 1'b1;
                            n_run      = make_run(SRC_NONE, KIND_EMPTY, FIX_ZERO,
                                                  CNT_W'(1), 8'd0, 1'b0);
                            unique case (i_req.request_code)
                                REQ_GET_STATUS: begin
                                    n_run = make_run(SRC_FIX, KIND_DATA, FIX_ZERO,
                                                     CNT_W'(2), 8'd0, 1'b0);
                                end
                                REQ_SET_ADDRESS: begin
                                    n_pend_addr = i_req.request_value[6:0];
                                    n_addr_pend = 1'b1;
                                end
                                REQ_GET_DESCRIPTOR: begin
                                    n_type   = i_req.request_value[15:8];
                                    n_index  = i_req.request_value[7:0];
                                    n_length = i_req.request_length;
                                    n_state  = ST_DESC;
                                    n_start  = 1'b0;
                                end
                                REQ_GET_CONFIG: begin
                                    n_run = make_run(SRC_FIX, KIND_DATA, FIX_CONFIG,
                                                     CNT_W'(1), 8'd0, 1'b0);
                                end
                                REQ_SET_CONFIG: begin
                                    n_config = i_req.request_value[7:0];
                                end
                                REQ_GET_LINE_CODING: begin
                                    n_run = make_run(SRC_FIX, KIND_DATA, FIX_LINE,
                                                     CNT_W'(8), 8'd0, 1'b0);
                                end
                                REQ_SET_LINE_STATE: begin
                                    n_line_st = i_req.request_value[7:0];
                                end
                                default: begin
                                    // Set line coding and unknown codes arm an empty packet.
                                end
                            endcase
                        end
                        ACT_IN: begin
                            // A pending address takes effect first.
                            if (r_addr_pend) begin
                                n_cur_addr  = r_pend_addr;
                                n_addr_pend = 1'b0;
                                n_addr_load = 1'b1;
                            end
                            if (r_resp_rem != 8'd0) begin
                                n_state = ST_SEND;
                            end else begin
                                n_state = ST_RUN;
                                n_start = 1'b1;
                                n_run   = make_run(SRC_NONE, KIND_STALL, FIX_ZERO,
                                                   CNT_W'(1), 8'd0, 1'b0);
                            end
                        end
                        ACT_RESET: begin
                            n_config    = 8'd0;
                            n_addr_pend = 1'b0;
                            n_pend_addr = 7'd0;
                            n_cur_addr  = 7'd0;
                            n_resp_ptr  = 8'd0;
                            n_resp_rem  = 8'd0;
                            n_addr_load = 1'b1;
                            n_state     = ST_RUN;
                            n_start     = 1'b1;
                            n_run       = make_run(SRC_NONE, KIND_RESET, FIX_ZERO,
                                                   CNT_W'(1), 8'd0, 1'b0);
                        end
                        default: begin
                            // The unused action code is dropped without a result.
                        end
                    endcase
                end
            end
            ST_DESC: begin
                if (!d_found) begin
                    n_state = ST_RUN;
                    n_start = 1'b1;
                    n_run   = make_run(SRC_NONE, KIND_NONE, FIX_ZERO,
                                       CNT_W'(1), 8'd0, 1'b0);
                end else if (d_clip == 8'd0) begin
                    n_state = ST_RUN;
                    n_start = 1'b1;
                    n_run   = make_run(SRC_NONE, KIND_EMPTY, FIX_ZERO,
                                       CNT_W'(1), 8'd0, 1'b0);
                end else begin
                    n_resp_ptr = d_off;
                    n_resp_rem = d_clip;
                    n_state    = ST_SEND;
                end
            end
            ST_SEND: begin
                // Cut the next packet off the pending transfer.
                n_resp_rem = s_rem;
                n_resp_ptr = (s_rem == 8'd0) ? 8'd0 : (r_resp_ptr + s_cnt);
                n_state    = ST_RUN;
                n_start    = 1'b1;
                n_run      = make_run(SRC_ROM, KIND_DATA, FIX_ZERO, s_cnt[CNT_W-1:0],
                                      r_resp_ptr, (s_rem != 8'd0));
            end
            ST_RUN: begin
                if (!r_start && !i_busy) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Control and device state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_config    <= 8'd0;
            r_line_st   <= 8'd0;
            r_pend_addr <= 7'd0;
            r_addr_pend <= 1'b0;
            r_cur_addr  <= 7'd0;
            r_resp_ptr  <= 8'd0;
            r_resp_rem  <= 8'd0;
            r_addr_load <= 1'b0;
            r_start     <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_config    <= n_config;
            r_line_st   <= n_line_st;
            r_pend_addr <= n_pend_addr;
            r_addr_pend <= n_addr_pend;
            r_cur_addr  <= n_cur_addr;
            r_resp_ptr  <= n_resp_ptr;
            r_resp_rem  <= n_resp_rem;
            r_addr_load <= n_addr_load;
            r_start     <= n_start;
        end
    end

    // Request fields and run descriptor.
    always_ff @(posedge i_clk) begin
        r_type   <= n_type;
        r_index  <= n_index;
        r_length <= n_length;
        r_run    <= n_run;
    end

    // Line rate register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_rate <= LINE_RATE_RESET;
        end else if (i_cfg_we) begin
            r_line_rate <= i_cfg_wdata;
        end
    end

    assign o_start            = r_start;
    assign o_run              = r_run;
    assign o_ctx.addr_load    = r_addr_load;
    assign o_ctx.dev_addr     = r_cur_addr;
    assign o_ctx.config_value = r_config;
    assign o_ctx.line_state   = r_line_st;
    assign o_ctx.line_rate    = r_line_rate;

endmodule

// File: rtl/core/usb_control_request_responder.sv
// ============================================================================
// USB control request responder
// Answers endpoint-0 requests from a fixed descriptor table and sends long
// descriptors packet by packet on each IN acknowledgement.
//
//   Channel   Direction  Carries
//   i_req     in         action, request_code, request_value, request_length
//   o_rsp     out        reply_kind, data_byte, last, more_to_come,
//                        address_load, device_address, configuration
//   i_cfg_*   in         line_rate write (write enable, 32-bit data)
//
// One item is taken at a time; an item sends N result beats, with N at most
// MAX_PACKET. A descriptor lookup passes through the lookup state, and a packet
// through the send state, before its run starts; an IN that sends a pending
// packet passes through the send state too. An unused action code retires
// without a result. i_req.ready rises at the edge after the last beat enters the
// output stage; holding off o_rsp delays it. Reset is synchronous and restores
// the device state and a line rate of 115200.
// ============================================================================
module usb_control_request_responder
    import usbcr_pkg::*;
#(
    parameter int MAX_PACKET = MAX_PACKET_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [31:0]       i_cfg_wdata,
    usbcr_req_if.sink         i_req,
    usbcr_rsp_if.source       o_rsp
);

    logic start;
    logic busy;
    t_run run;
    t_ctx ctx;

    // Request sequencer and device state.
    usbcr_ctrl #(
        .MAX_PACKET (MAX_PACKET)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_req       (i_req),
        .i_busy      (busy),
        .o_start     (start),
        .o_run       (run),
        .o_ctx       (ctx)
    );

    // Shared byte unit and output stage.
    usbcr_emit u_emit (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_run   (run),
        .i_ctx   (ctx),
        .o_busy  (busy),
        .o_rsp   (o_rsp)
    );

endmodule
